// ----- hdl/bitmap_page_allocator_defines.svh -----
// assertion macros for the page allocator checker
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BPA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bpa check failed");

// next-cycle implication, disabled while reset is low
`define BPA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bpa check failed");

`endif

// ----- hdl/bpa_pkg.sv -----
// shared types and constants of the bitmap page allocator
package bpa_pkg;

  localparam int unsigned DefNumPages = 65536;
  localparam int unsigned DefWordBits = 64;

  // fixed field widths of the request and response words
  localparam int unsigned ActionW  = 2;
  localparam int unsigned PageW    = 16;
  localparam int unsigned RegionW  = 17;
  localparam int unsigned CountW   = 17;

  // bit index / bit count inside one map word (word size at most 64)
  localparam int unsigned BitIdxW  = 7;

  typedef enum logic [ActionW-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_INIT  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_BACK,
    ST_DIV_FIX,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_WR,
    ST_FINISH
  } state_e;

  // word unit control: bit range [lo, lo+n) and direction
  typedef struct packed {
    logic [BitIdxW-1:0] lo;
    logic [BitIdxW-1:0] n;
    logic               set_bits;
  } wu_ctrl_t;

  // word unit status: first clear bit, full flag, changed bit count
  typedef struct packed {
    logic [BitIdxW-1:0] ffz;
    logic               all_ones;
    logic [BitIdxW-1:0] pop;
  } wu_stat_t;

endpackage

// ----- hdl/bpa_ifs.sv -----
// request and response channel interfaces of the page allocator
interface bpa_req_if;
  import bpa_pkg::*;

  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [PageW-1:0]   page_number;
  logic [RegionW-1:0] region_pages;
  logic               region_available;

  modport source (
    output valid, action, page_number, region_pages, region_available,
    input  ready
  );
  modport sink (
    input  valid, action, page_number, region_pages, region_available,
    output ready
  );
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [PageW-1:0]  granted_page;
  logic              grant_ok;
  logic [CountW-1:0] free_pages;

  modport source (
    output valid, granted_page, grant_ok, free_pages,
    input  ready
  );
  modport sink (
    input  valid, granted_page, grant_ok, free_pages,
    output ready
  );
endinterface

// ----- hdl/bitmap_page_allocator.sv -----
// bitmap page allocator top level: sequencer, free count and output register
//
//   channel | dir | word                                          | accepted when
//   req_i   | in  | action, page_number, region_pages, avail flag | valid && ready
//   rsp_o   | out | granted_page, grant_ok, free_pages            | valid && ready
//
// allocate: scans map words from the scan start; with no free page it goes straight to the result
// free and init region: divide the page number, then walk the map words touched; no-op: straight to the result
// all map traffic goes through the map memory (one write port, one read port) and one shared word unit
// after reset a fill pass writes every map word to all ones,
//   one word a cycle, with req ready low
// a result waits in an output register, so the next word is taken while rsp_o stalls
module bitmap_page_allocator #(
  parameter int unsigned NUM_PAGES = bpa_pkg::DefNumPages,
  parameter int unsigned WORD_BITS = bpa_pkg::DefWordBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bpa_req_if.sink         req_i,
  bpa_rsp_if.source       rsp_o
);
  import bpa_pkg::*;

  // map geometry
  localparam int unsigned MapWords = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW       = (MapWords > 1) ? $clog2(MapWords) : 1;
  // page positions up to and including NUM_PAGES, and page + region length
  localparam int unsigned SpanW    = $clog2(NUM_PAGES + 1);
  localparam int unsigned ExtW     = ((SpanW > RegionW) ? SpanW : RegionW) + 1;
  localparam int unsigned CntW     = SpanW;
  // word index of any 16-bit page number
  localparam int unsigned StartW   = $clog2(((1 << PageW) - 1) / WORD_BITS + 1);
  localparam int unsigned WcW      = (StartW > AW + 1) ? StartW : AW + 1;
  // page / WORD_BITS by reciprocal multiply, one correction step
  localparam int unsigned RecipSh  = PageW + 8;
  localparam int unsigned Recip    = (1 << RecipSh) / WORD_BITS;
  localparam int unsigned RecipW   = $clog2(Recip + 1);
  localparam int unsigned ProdW    = PageW + RecipW;
  localparam int unsigned QwW      = StartW + BitIdxW;

  state_e state_q, state_d;

  // control registers
  logic [WcW-1:0]       w_q;
  logic                 known_q;
  logic [CntW-1:0]      count_q, count_d;
  logic                 pend_q;
  logic                 out_valid_q;

  // item and datapath registers
  logic [PageW-1:0]     page_q;
  logic [ExtW-1:0]      end_q;
  logic [ExtW-1:0]      p_q;
  logic                 set_q;
  logic                 seed_q;
  logic [ProdW-1:0]     prod_q;
  logic [StartW-1:0]    q_q;
  logic [PageW-1:0]     qw_q;
  logic [StartW-1:0]    start_q;
  logic [BitIdxW-1:0]   lo_q;
  logic [BitIdxW-1:0]   n_q;
  logic [BitIdxW-1:0]   b_q;
  logic [BitIdxW-1:0]   pop_q;
  logic                 pend_sub_q;
  logic [PageW-1:0]     grant_q;
  logic                 ok_q;
  logic [PageW-1:0]     out_page_q;
  logic                 out_ok_q;
  logic [CountW-1:0]    out_free_q;

  // memory and word unit hookup
  logic                 mem_we;
  logic                 mem_re;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;
  logic [WORD_BITS-1:0] wu_new_word;
  wu_ctrl_t             wu_ctrl;
  wu_stat_t             wu_stat;

  // helpers
  action_e              req_act;
  logic                 req_fire;
  logic                 rsp_fire;
  logic                 out_load;
  logic [ExtW-1:0]      req_len;
  logic [ExtW-1:0]      req_sum;
  logic [ExtW-1:0]      req_end;
  logic [StartW-1:0]    q_est;
  logic [QwW-1:0]       qw_full;
  logic [PageW-1:0]     r_raw;
  logic [StartW-1:0]    q_fix;
  logic [BitIdxW-1:0]   lo_fix;
  logic                 walk_go;
  logic                 walk_last;
  logic [ExtW-1:0]      rem;
  logic [BitIdxW-1:0]   room;
  logic [BitIdxW-1:0]   n_calc;
  logic                 scan_end;
  logic [ExtW-1:0]      grant_calc;

  bpa_map_mem #(
    .WORD_BITS (WORD_BITS),
    .DEPTH     (MapWords),
    .AW        (AW)
  ) u_map_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (w_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (w_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  bpa_word_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_word_unit (
    .word_i     (mem_rdata),
    .ctrl_i     (wu_ctrl),
    .new_word_o (wu_new_word),
    .stat_o     (wu_stat)
  );

  // ------------------------------------------------------------------
  // request decode and region end, clipped at the map size
  // ------------------------------------------------------------------
  always_comb begin
    req_act  = action_e'(req_i.action);
    req_fire = req_i.valid && req_i.ready;
    rsp_fire = rsp_o.valid && rsp_o.ready;
    if (req_act == ACT_FREE) begin
      req_len = ExtW'(1);
    end else begin
      req_len = ExtW'(req_i.region_pages);
    end
    req_sum = ExtW'(req_i.page_number) + req_len;
    req_end = (req_sum > ExtW'(NUM_PAGES)) ? ExtW'(NUM_PAGES) : req_sum;
  end

  // ------------------------------------------------------------------
  // word index and bit offset of page_q: q_est is exact or one short
  // ------------------------------------------------------------------
  always_comb begin
    q_est   = StartW'(prod_q >> RecipSh);
    qw_full = QwW'(q_est) * QwW'(WORD_BITS);
    r_raw   = page_q - qw_q;
    if (r_raw >= PageW'(WORD_BITS)) begin
      q_fix  = q_q + StartW'(1);
      lo_fix = BitIdxW'(r_raw - PageW'(WORD_BITS));
    end else begin
      q_fix  = q_q;
      lo_fix = BitIdxW'(r_raw);
    end
    walk_go = ExtW'(page_q) < end_q;
  end

  // ------------------------------------------------------------------
  // region walk: pages of the current word that fall in [p, end)
  // ------------------------------------------------------------------
  always_comb begin
    rem       = end_q - p_q;
    room      = BitIdxW'(WORD_BITS) - lo_q;
    n_calc    = (rem < ExtW'(room)) ? BitIdxW'(rem) : room;
    walk_last = (p_q + ExtW'(n_q)) >= end_q;
    scan_end  = w_q >= WcW'(MapWords);
    grant_calc = ExtW'(w_q) * ExtW'(WORD_BITS) + ExtW'(b_q);
  end

  // ------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (w_q == WcW'(MapWords - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (req_act) inside
            ACT_ALLOC:          state_d = (count_q == '0) ? ST_FINISH : ST_SCAN_RD;
            ACT_FREE, ACT_INIT: state_d = ST_DIV_MUL;
            default:            state_d = ST_FINISH;
          endcase
        end
      end
      ST_DIV_MUL:  state_d = ST_DIV_BACK;
      ST_DIV_BACK: state_d = ST_DIV_FIX;
      ST_DIV_FIX:  state_d = walk_go ? ST_WALK_RD : ST_FINISH;
      ST_WALK_RD:  state_d = ST_WALK_WR;
      ST_WALK_WR:  state_d = walk_last ? ST_FINISH : ST_WALK_RD;
      ST_SCAN_RD:  state_d = scan_end ? ST_FINISH : ST_SCAN_CHK;
      ST_SCAN_CHK: state_d = wu_stat.all_ones ? ST_SCAN_RD : ST_SCAN_WR;
      ST_SCAN_WR:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_load) state_d = ST_IDLE;
      end
      default:     state_d = ST_CLEAR;
    endcase
  end

  // ------------------------------------------------------------------
  // sequencer outputs: memory port, word unit control, handshakes
  // ------------------------------------------------------------------
  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_wdata    = wu_new_word;
    wu_ctrl      = '0;
    req_i.ready  = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '1;
      end
      ST_IDLE:    req_i.ready = 1'b1;
      ST_WALK_RD: mem_re = 1'b1;
      ST_WALK_WR: begin
        wu_ctrl = '{lo: lo_q, n: n_q, set_bits: set_q};
        mem_we  = 1'b1;
      end
      ST_SCAN_RD: mem_re = !scan_end;
      ST_SCAN_WR: begin
        // mark the found page used
        wu_ctrl = '{lo: b_q, n: BitIdxW'(1), set_bits: 1'b1};
        mem_we  = 1'b1;
      end
      ST_FINISH:  out_load = !out_valid_q || rsp_o.ready;
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // free count follows the bits that really changed in the last write
  always_comb begin
    count_d = count_q;
    if (pend_q) begin
      if (pend_sub_q) begin
        count_d = count_q - CntW'(pop_q);
      end else begin
        count_d = count_q + CntW'(pop_q);
      end
    end
  end

  // ------------------------------------------------------------------
  // control registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      w_q         <= '0;
      known_q     <= 1'b0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= (state_q == ST_WALK_WR) || (state_q == ST_SCAN_WR);

      unique case (state_q)
        ST_CLEAR: w_q <= w_q + WcW'(1);
        ST_IDLE: begin
          // allocate starts at the scan start once one is known
          if (req_fire) w_q <= known_q ? WcW'(start_q) : '0;
        end
        ST_DIV_FIX: begin
          w_q <= WcW'(q_fix);
          if (seed_q) known_q <= 1'b1;
        end
        ST_WALK_WR: w_q <= w_q + WcW'(1);
        ST_SCAN_CHK: begin
          if (wu_stat.all_ones) w_q <= w_q + WcW'(1);
        end
        default: begin
          w_q <= w_q;
        end
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // datapath registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          page_q  <= req_i.page_number;
          end_q   <= req_end;
          set_q   <= (req_act == ACT_INIT) && !req_i.region_available;
          seed_q  <= (req_act == ACT_INIT) && req_i.region_available && !known_q;
          grant_q <= '0;
          ok_q    <= 1'b0;
        end
      end
      ST_DIV_MUL:  prod_q <= ProdW'(page_q) * ProdW'(Recip);
      ST_DIV_BACK: begin
        q_q  <= q_est;
        qw_q <= PageW'(qw_full);
      end
      ST_DIV_FIX: begin
        lo_q <= lo_fix;
        p_q  <= ExtW'(page_q);
        if (seed_q) start_q <= q_fix;
      end
      ST_WALK_RD:  n_q <= n_calc;
      ST_WALK_WR: begin
        p_q        <= p_q + ExtW'(n_q);
        lo_q       <= '0;
        pop_q      <= wu_stat.pop;
        pend_sub_q <= set_q;
      end
      ST_SCAN_CHK: b_q <= wu_stat.ffz;
      ST_SCAN_WR: begin
        grant_q    <= PageW'(grant_calc);
        ok_q       <= 1'b1;
        pop_q      <= wu_stat.pop;
        pend_sub_q <= 1'b1;
      end
      ST_FINISH: begin
        if (out_load) begin
          out_page_q <= grant_q;
          out_ok_q   <= ok_q;
          out_free_q <= CountW'(count_d);
        end
      end
      default: begin
        b_q <= b_q;
      end
    endcase
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted_page = out_page_q;
  assign rsp_o.grant_ok     = out_ok_q;
  assign rsp_o.free_pages   = out_free_q;

endmodule

// ----- hdl/bpa_word_unit.sv -----
// shared map word unit: range mask, set/clear, changed-bit count, first clear bit
module bpa_word_unit #(
  parameter int unsigned WORD_BITS = bpa_pkg::DefWordBits
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  bpa_pkg::wu_ctrl_t    ctrl_i,
  output logic [WORD_BITS-1:0] new_word_o,
  output bpa_pkg::wu_stat_t    stat_o
);
  import bpa_pkg::*;

  localparam int unsigned NBytes = (WORD_BITS + 7) / 8;
  localparam int unsigned PadW   = NBytes * 8;

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] changed;
  logic [BitIdxW:0]     hi;
  logic [PadW-1:0]      word_pad;
  logic [PadW-1:0]      changed_pad;
  logic [3:0]           byte_pop [NBytes];
  logic [2:0]           byte_ffz [NBytes];
  logic [NBytes-1:0]    byte_zero;

  // bit range mask and the updated word
  always_comb begin
    hi = {1'b0, ctrl_i.lo} + {1'b0, ctrl_i.n};
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = ((BitIdxW+1)'(i) >= {1'b0, ctrl_i.lo}) && ((BitIdxW+1)'(i) < hi);
    end
    if (ctrl_i.set_bits) begin
      changed    = mask & ~word_i;
      new_word_o = word_i | mask;
    end else begin
      changed    = mask & word_i;
      new_word_o = word_i & ~mask;
    end
  end

  // per byte: changed count and lowest clear bit
  always_comb begin
    word_pad                     = '1;
    word_pad[WORD_BITS-1:0]      = word_i;
    changed_pad                  = '0;
    changed_pad[WORD_BITS-1:0]   = changed;
    for (int j = 0; j < NBytes; j++) begin
      byte_pop[j] = '0;
      byte_ffz[j] = '0;
      for (int k = 7; k >= 0; k--) begin
        byte_pop[j] = byte_pop[j] + 4'(changed_pad[8*j+k]);
        if (!word_pad[8*j+k]) begin
          byte_ffz[j] = 3'(k);
        end
      end
      byte_zero[j] = ~&word_pad[8*j +: 8];
    end
  end

  // combine bytes
  always_comb begin
    stat_o          = '0;
    stat_o.all_ones = &word_i;
    for (int j = 0; j < NBytes; j++) begin
      stat_o.pop = stat_o.pop + BitIdxW'(byte_pop[j]);
    end
    for (int j = NBytes - 1; j >= 0; j--) begin
      if (byte_zero[j]) begin
        stat_o.ffz = BitIdxW'({3'(j), byte_ffz[j]});
      end
    end
  end

endmodule

// ----- hdl/bpa_map_mem.sv -----
// used-page map storage, one write port and one registered read port
module bpa_map_mem #(
  parameter int unsigned WORD_BITS = bpa_pkg::DefWordBits,
  parameter int unsigned DEPTH     = bpa_pkg::DefNumPages / bpa_pkg::DefWordBits,
  parameter int unsigned AW        = 10
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hdl/bpa_checker.sv -----
// port-level checker of the page allocator and its bind
`include "bitmap_page_allocator_defines.svh"

module bpa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [bpa_pkg::PageW-1:0]  granted_page_i,
  input logic                       grant_ok_i,
  input logic [bpa_pkg::CountW-1:0] free_pages_i
);
  import bpa_pkg::*;

  // a failed or non-allocate word carries page zero
  `BPA_ASSERT_IMPL(a_fail_page_zero, clk_i, rst_ni, rsp_valid_i && !grant_ok_i, granted_page_i == '0)

  // the block is busy right after taking a request
  `BPA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // a stalled response keeps its word
  `BPA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(granted_page_i) && $stable(grant_ok_i) && $stable(free_pages_i))

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .granted_page_i (rsp_o.granted_page),
  .grant_ok_i     (rsp_o.grant_ok),
  .free_pages_i   (rsp_o.free_pages)
);

// ----- dv/tb_bitmap_page_allocator.sv -----
// testbench of the bitmap page allocator: directed and random words checked against a predictor
module tb_bitmap_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int unsigned NUM_PAGES = DefNumPages;
  localparam int unsigned WORD_BITS = DefWordBits;
  localparam int unsigned MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;

  // random part and the idling phases, counted in request words
  localparam int unsigned RANDOM_WORDS = 1880;
  localparam int unsigned PHASE_B_AT   = 630;
  localparam int unsigned PHASE_C_AT   = 1260;

  // long receiver hold-off, in cycles, so the output register fills and req stalls
  localparam int unsigned RSP_HOLD_CYCLES = 400;

  // slowest word: a full map walk plus overhead
  localparam int unsigned DRAIN_CYCLES = 2 * MAP_WORDS + 200;

  // slowest correct run: every word a full walk plus the longest stalls, taken
  // several times over, plus the fill pass after reset
  localparam longint unsigned LIMIT_CYCLES = 40_000_000;

  // expected result word of one request, plus the predicted map state
  class page_map_scoreboard;
    typedef struct packed {
      logic [PageW-1:0]  page;
      logic              ok;
      logic [CountW-1:0] count;
    } grant_word_t;

    bit [WORD_BITS-1:0] used_map [MAP_WORDS];
    int unsigned        free_cnt;
    int unsigned        scan_word;
    bit                 scan_known;
    grant_word_t        grants_due [$];
    int unsigned        granted_pages [$];
    int unsigned        errors;

    function new();
      foreach (used_map[w]) used_map[w] = '1;
      free_cnt   = 0;
      scan_word  = 0;
      scan_known = 1'b0;
      errors     = 0;
    endfunction

    // count moves only when the page bit really flips
    function void mark_page(int unsigned pg, bit used);
      int unsigned w;
      int unsigned b;
      w = pg / WORD_BITS;
      b = pg % WORD_BITS;
      if (used && !used_map[w][b]) begin
        used_map[w][b] = 1'b1;
        if (free_cnt > 0) free_cnt--;
      end else if (!used && used_map[w][b]) begin
        used_map[w][b] = 1'b0;
        if (free_cnt < NUM_PAGES) free_cnt++;
      end
    endfunction

    // accepted request: update the map and queue the word it must produce
    function void apply_request(action_e act, logic [PageW-1:0] pg,
                                logic [RegionW-1:0] np, logic av);
      grant_word_t g;
      int unsigned w;
      int unsigned b;
      int unsigned hit;
      int unsigned last;
      bit          found;
      g     = '0;
      found = 1'b0;
      hit   = 0;
      case (act)
        ACT_ALLOC: begin
          // first fit from the scan start, never wrapping below it
          if (free_cnt != 0) begin
            for (w = scan_known ? scan_word : 0; w < MAP_WORDS && !found; w++) begin
              if (used_map[w] != '1) begin
                for (b = 0; b < WORD_BITS && !found; b++) begin
                  if (!used_map[w][b]) begin
                    found = 1'b1;
                    hit   = w * WORD_BITS + b;
                  end
                end
              end
            end
          end
          if (found) begin
            mark_page(hit, 1'b1);
            g.page = PageW'(hit);
            g.ok   = 1'b1;
            granted_pages.push_back(hit);
          end
        end
        ACT_FREE: begin
          if (pg < NUM_PAGES) mark_page(pg, 1'b0);
        end
        ACT_INIT: begin
          // region clipped at the map end; first free region fixes the scan start
          last = pg + np;
          if (last > NUM_PAGES) last = NUM_PAGES;
          if (av && !scan_known) begin
            scan_word  = pg / WORD_BITS;
            scan_known = 1'b1;
          end
          for (int unsigned p = pg; p < last; p++) mark_page(p, !av);
        end
        default: ;
      endcase
      g.count = CountW'(free_cnt);
      grants_due.push_back(g);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_grant(logic [PageW-1:0] page, logic ok, logic [CountW-1:0] count);
      grant_word_t want;
      if (grants_due.size() == 0) begin
        report($sformatf("result word with nothing due: page %0d ok %b free %0d",
                         page, ok, count));
        return;
      end
      want = grants_due.pop_front();
      if (page !== want.page)
        report($sformatf("granted_page %0d, want %0d", page, want.page));
      if (ok !== want.ok)
        report($sformatf("grant_ok %b, want %b", ok, want.ok));
      if (count !== want.count)
        report($sformatf("free_pages %0d, want %0d", count, want.count));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  bpa_req_if req_if ();
  bpa_rsp_if rsp_if ();

  bitmap_page_allocator #(
    .NUM_PAGES (NUM_PAGES),
    .WORD_BITS (WORD_BITS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  page_map_scoreboard sb;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  bit                 hold_rsp;
  longint unsigned    cycle_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit, in case the block hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // offer one request word from a falling edge, hold it until taken,
  // return on the falling edge after acceptance
  task automatic send_word(action_e act, logic [PageW-1:0] pg,
                           logic [RegionW-1:0] np, logic av);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.action           <= act;
    req_if.page_number      <= pg;
    req_if.region_pages     <= np;
    req_if.region_available <= av;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.apply_request(act, pg, np, av);
    @(negedge clk_i);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(negedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // every accepted result word goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_grant(rsp_if.granted_page, rsp_if.grant_ok, rsp_if.free_pages);
  end

  initial begin : stimulus
    int unsigned        sel;
    int unsigned        idx;
    action_e            act;
    logic [PageW-1:0]   pg;
    logic [RegionW-1:0] np;
    logic               av;

    sb                      = new();
    cycle_count             = 0;
    hold_rsp                = 1'b0;
    send_idle_pct           = 14;
    recv_idle_pct           = 87;
    req_if.valid            = 1'b0;
    req_if.action           = ACT_NOP;
    req_if.page_number      = '0;
    req_if.region_pages     = '0;
    req_if.region_available = 1'b0;
    rst_ni                  = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part; the block runs its fill pass first with req ready low
    send_word(ACT_ALLOC, 16'h0000, 17'h00000, 1'b0); // nothing free: fails
    send_word(ACT_NOP,   16'hFFFF, 17'h1FFFF, 1'b1); // no-op with every bit set
    send_word(ACT_FREE,  16'h0003, 17'h00000, 1'b0); // free a used page
    send_word(ACT_ALLOC, 16'h0000, 17'h00000, 1'b0); // scan start unknown: word 0
    send_word(ACT_INIT,  16'h1234, 17'h00000, 1'b0); // empty reserved region
    send_word(ACT_INIT,  16'h0080, 17'h00000, 1'b1); // empty free region sets scan start
    send_word(ACT_INIT,  16'h0080, 17'd300,   1'b1);
    send_word(ACT_INIT,  16'h0000, 17'd64,    1'b1); // free pages below the scan start
    send_word(ACT_ALLOC, 16'h0000, 17'h00000, 1'b0);
    send_word(ACT_ALLOC, 16'h0000, 17'h00000, 1'b0);
    send_word(ACT_FREE,  16'h0080, 17'h00000, 1'b0);
    send_word(ACT_FREE,  16'h0080, 17'h00000, 1'b0); // free page already free
    send_word(ACT_INIT,  16'h0081, 17'd1,     1'b0); // reserve a page already used
    send_word(ACT_INIT,  16'h0082, 17'd4,     1'b0); // reserve free pages
    send_word(ACT_ALLOC, 16'h0000, 17'h00000, 1'b0);
    send_word(ACT_INIT,  16'hFFC0, 17'h1FFFF, 1'b1); // region clipped at the map end
    send_word(ACT_FREE,  16'hFFFF, 17'h00000, 1'b0);
    send_word(ACT_INIT,  16'h0000, 17'h10000, 1'b1); // whole map free, count at top
    send_word(ACT_INIT,  16'h0000, 17'h10000, 1'b0); // whole map used
    send_word(ACT_ALLOC, 16'h0000, 17'h00000, 1'b0); // count zero: fails
    send_word(ACT_FREE,  16'h0005, 17'h00000, 1'b0); // only free page is below scan start
    send_word(ACT_ALLOC, 16'h0000, 17'h00000, 1'b0); // no wrap: walks to the end, fails
    send_word(ACT_INIT,  16'h0100, 17'd1024,  1'b1);
    send_word(ACT_ALLOC, 16'h0000, 17'h00000, 1'b0);

    // random part: mostly allocs and frees of granted pages over small regions
    // above the scan start; a few wide regions and stray frees anywhere
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n == PHASE_B_AT) begin
        send_idle_pct = 87;
        recv_idle_pct = 14;
      end
      if (n == PHASE_C_AT) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_rsp      = 1'b1;
      end
      sel = $urandom_range(99);
      pg  = PageW'($urandom_range(65535));
      np  = RegionW'($urandom_range(131071));
      av  = 1'($urandom_range(1));
      if (sel < 40) begin
        act = ACT_ALLOC;
      end else if (sel < 72) begin
        act = ACT_FREE;
        if (sb.granted_pages.size() != 0 && $urandom_range(9) < 7) begin
          idx = $urandom_range(sb.granted_pages.size() - 1);
          pg  = PageW'(sb.granted_pages[idx]);
          sb.granted_pages.delete(idx);
        end
      end else if (sel < 90) begin
        act = ACT_INIT;
        pg  = PageW'($urandom_range(4095, 128));
        np  = RegionW'($urandom_range(300));
        av  = ($urandom_range(9) < 7);
      end else if (sel < 95) begin
        act = ACT_NOP;
      end else if (sel < 98) begin
        // wide region, random start, clipped at the map end
        act = ACT_INIT;
      end else begin
        act = ACT_FREE;
      end
      send_word(act, pg, np, av);
    end
    req_if.valid <= 1'b0;

    // drain, then give a stray word time to show up
    while (sb.grants_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
